/* hdl/vrt_pkg.sv */
// Package: shared constants, types and codes for the voxel ray traversal block.
package vrt_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int BLOCK_ID_BITS_DEF = 8;
	localparam int TIME_W = 40;
	localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

	localparam logic [1:0] KIND_QUERY = 2'd0;
	localparam logic [1:0] KIND_HIT = 2'd1;
	localparam logic [1:0] KIND_MISS = 2'd2;
	localparam logic [1:0] KIND_IDLE = 2'd3;

	localparam logic [2:0] FACE_TOP = 3'd0;
	localparam logic [2:0] FACE_BOT = 3'd1;
	localparam logic [2:0] FACE_NORTH = 3'd2;
	localparam logic [2:0] FACE_SOUTH = 3'd3;
	localparam logic [2:0] FACE_EAST = 3'd4;
	localparam logic [2:0] FACE_WEST = 3'd5;

	// Request to the shared divider: numerator and divisor, 64 bits each.
	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [63:0] den;
	} vrt_div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quo;
	} vrt_div_rsp_t;
endpackage

/* hdl/vrt_divider.sv */
// Shared restoring divider, one quotient bit per cycle.
module vrt_divider
	import vrt_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  vrt_div_req_t req,
	output vrt_div_rsp_t rsp
);
	logic [63:0] quo_q;
	logic [63:0] rem_q;
	logic [63:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] trial;

	assign trial = {rem_q, quo_q[63]} - {1'b0, den_q};

	// Shift one numerator bit into the remainder each cycle while busy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[64] && (rem_q[63] == 1'b0)) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else if (rem_q[63]) begin
				rem_q <= trial[63:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= {rem_q[62:0], quo_q[63]};
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo = quo_q;
endmodule

/* hdl/voxel_ray_traversal_top.sv */
// Top level: ray setup sequencer, traversal step and result register.
// Start item: squares, square root, then up to nine divisions on one shared
// divider. Answer item: a step, a reply with no active ray, a hit or a miss
// (one shared 18x41 multiply per axis for hit and miss).
// The next item is accepted only after the result is taken. Reset (arst_n low)
// clears all control state; no ray is active after it.
module voxel_ray_traversal_top
	import vrt_pkg::*;
#(
	parameter int BLOCK_ID_BITS = BLOCK_ID_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               action,
	input  logic signed [31:0] origin_x,
	input  logic signed [31:0] origin_y,
	input  logic signed [31:0] origin_z,
	input  logic signed [31:0] heading_x,
	input  logic signed [31:0] heading_y,
	input  logic signed [31:0] heading_z,
	input  logic [30:0]        length_limit,
	input  logic [7:0]         occupancy,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic signed [15:0] voxel_x,
	output logic signed [15:0] voxel_y,
	output logic signed [15:0] voxel_z,
	output logic [7:0]         hit_block,
	output logic [2:0]         face,
	output logic [30:0]        distance,
	output logic signed [31:0] point_x,
	output logic signed [31:0] point_y,
	output logic signed [31:0] point_z
);
	localparam int FB = FRAC_BITS_DEF;
	localparam logic [7:0] BLK_MASK = 8'((17'd1 << BLOCK_ID_BITS) - 17'd1);

	typedef enum logic [9:0] {
		ST_IDLE  = 10'b0000000001,
		ST_SQ    = 10'b0000000010,
		ST_SQRT  = 10'b0000000100,
		ST_DIV   = 10'b0000001000,
		ST_DWAIT = 10'b0000010000,
		ST_STEP  = 10'b0000100000,
		ST_PMUL  = 10'b0001000000,
		ST_PADD  = 10'b0010000000,
		ST_OUT   = 10'b0100000000,
		ST_SETUP = 10'b1000000000
	} state_t;

	state_t state_q;
	logic [1:0] ax_q;
	logic [2:0] dix_q;
	logic [5:0] cnt_q;

	logic              active_q;
	logic signed [31:0] sp_q [3];
	logic signed [31:0] hd_q [3];
	logic signed [17:0] uh_q [3];
	logic [15:0]       vox_q [3];
	logic [TIME_W-1:0] nc_q [3];
	logic [TIME_W-1:0] ci_q [3];
	logic [TIME_W-1:0] trav_q;
	logic [2:0]        face_q;
	logic [30:0]       lim_q;
	logic [65:0]       sq_q;
	logic [63:0]       sqn_q;
	logic [63:0]       root_q;
	logic [63:0]       bit_q;
	logic [31:0]       len_q;
	logic [TIME_W-1:0] pt_t_q;
	logic signed [72:0] prod_q;
	logic [1:0]        okind_q;
	logic [7:0]        oblk_q;

	logic [1:0]        r_kind_q;
	logic [15:0]       r_vox_q [3];
	logic [7:0]        r_blk_q;
	logic [2:0]        r_face_q;
	logic [30:0]       r_dist_q;
	logic signed [31:0] r_pt_q [3];
	logic              r_valid_q;

	vrt_div_req_t dreq;
	vrt_div_rsp_t drsp;

	vrt_divider u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	logic accept;
	assign in_stall = (state_q != ST_IDLE) || r_valid_q;
	assign accept = in_valid && !in_stall;

	// Per-axis magnitudes of the current axis.
	logic [31:0] hmag;
	logic [17:0] umag;
	logic [FB-1:0] frac;
	logic [FB:0] dist_d;
	assign hmag = hd_q[ax_q][31] ? 32'(-hd_q[ax_q]) : 32'(hd_q[ax_q]);
	assign umag = uh_q[ax_q][17] ? 18'(-uh_q[ax_q]) : 18'(uh_q[ax_q]);
	assign frac = sp_q[ax_q][FB-1:0];
	assign dist_d = uh_q[ax_q][17] ? {1'b0, frac} : ((FB+1)'(1) << FB) - {1'b0, frac};

	// Divider operands: dix 0 unit heading, 1 interval, 2 first crossing.
	always_comb begin
		dreq.start = (state_q == ST_DIV);
		dreq.den = 64'(umag);
		case (dix_q)
			3'd0: begin
				dreq.num = 64'(hmag) << FB;
				dreq.den = 64'(len_q);
			end
			3'd1: dreq.num = 64'd1 << (2 * FB);
			default: dreq.num = 64'(dist_d) << FB;
		endcase
	end

	logic [TIME_W-1:0] qsat;
	assign qsat = (drsp.quo > 64'(TIME_MAX)) ? TIME_MAX : drsp.quo[TIME_W-1:0];

	// Step selection: least crossing time, ties to the later axis (y over x, z over both).
	logic [1:0] sax;
	always_comb begin
		if (nc_q[0] < nc_q[1]) sax = (nc_q[0] < nc_q[2]) ? 2'd0 : 2'd2;
		else sax = (nc_q[1] < nc_q[2]) ? 2'd1 : 2'd2;
	end
	logic [TIME_W:0] ncsum;
	assign ncsum = {1'b0, nc_q[sax]} + {1'b0, ci_q[sax]};

	logic signed [72:0] sh;
	logic signed [73:0] psum;
	assign sh = prod_q >>> FB;
	assign psum = 74'(sp_q[ax_q]) + 74'(sh);

	logic [65:0] sqterm;
	assign sqterm = 66'(hmag) * 66'(hmag);

	logic [7:0] blk;
	assign blk = occupancy & BLK_MASK;

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			active_q <= 1'b0;
			r_valid_q <= 1'b0;
			ax_q <= '0;
			dix_q <= '0;
			cnt_q <= '0;
		end else begin
			if (r_valid_q && !out_stall) r_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (!action) begin
							ax_q <= 2'd0;
							state_q <= ST_SQ;
						end else if (!active_q) begin
							okind_q <= KIND_IDLE;
							state_q <= ST_OUT;
						end else if (blk != '0) begin
							okind_q <= KIND_HIT;
							oblk_q <= blk;
							pt_t_q <= trav_q;
							ax_q <= 2'd0;
							active_q <= 1'b0;
							state_q <= ST_PMUL;
						end else begin
							state_q <= ST_STEP;
						end
					end
				end
				ST_SQ: begin
					ax_q <= ax_q + 2'd1;
					if (ax_q == 2'd2) begin
						cnt_q <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd31) begin
						ax_q <= 2'd0;
						dix_q <= 3'd0;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					if ((dix_q == 3'd0 && len_q != '0) || (dix_q != 3'd0 && dix_q != 3'd3
					    && uh_q[ax_q] != '0))
						state_q <= ST_DIV;
					else if (dix_q == 3'd3 || (dix_q == 3'd0 && len_q == '0)
					    || uh_q[ax_q] == '0) begin
						if (ax_q == 2'd2) begin
							if (dix_q == 3'd0 || (dix_q == 3'd3 && 1'b0)) begin
								ax_q <= 2'd0;
								dix_q <= 3'd1;
							end else begin
								okind_q <= KIND_QUERY;
								active_q <= 1'b1;
								state_q <= ST_OUT;
							end
						end else begin
							ax_q <= ax_q + 2'd1;
							dix_q <= (dix_q == 3'd0) ? 3'd0 : 3'd1;
						end
					end
				end
				ST_DIV: state_q <= ST_DWAIT;
				ST_DWAIT: begin
					if (drsp.done) begin
						if (dix_q == 3'd0) begin
							if (ax_q == 2'd2) begin
								ax_q <= 2'd0;
								dix_q <= 3'd1;
							end else ax_q <= ax_q + 2'd1;
							state_q <= ST_SETUP;
						end else if (dix_q == 3'd1) begin
							dix_q <= 3'd2;
							state_q <= ST_DIV;
						end else begin
							dix_q <= 3'd3;
							state_q <= ST_SETUP;
						end
					end
				end
				ST_STEP: begin
					if (nc_q[sax] > 40'(lim_q)) begin
						okind_q <= KIND_MISS;
						pt_t_q <= 40'(lim_q);
						ax_q <= 2'd0;
						active_q <= 1'b0;
						state_q <= ST_PMUL;
					end else begin
						okind_q <= KIND_QUERY;
						state_q <= ST_OUT;
					end
				end
				ST_PMUL: state_q <= ST_PADD;
				ST_PADD: begin
					ax_q <= ax_q + 2'd1;
					state_q <= (ax_q == 2'd2) ? ST_OUT : ST_PMUL;
				end
				ST_OUT: begin
					r_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept && !action) begin
					sp_q[0] <= origin_x; sp_q[1] <= origin_y; sp_q[2] <= origin_z;
					hd_q[0] <= heading_x; hd_q[1] <= heading_y; hd_q[2] <= heading_z;
					lim_q <= length_limit;
					trav_q <= '0;
					face_q <= FACE_TOP;
					sq_q <= '0;
					for (int i = 0; i < 3; i++) begin
						uh_q[i] <= '0;
						nc_q[i] <= TIME_MAX;
						ci_q[i] <= TIME_MAX;
					end
					vox_q[0] <= origin_x[FB+15:FB];
					vox_q[1] <= origin_y[FB+15:FB];
					vox_q[2] <= origin_z[FB+15:FB];
				end
			end
			ST_SQ: begin
				sq_q <= sq_q + sqterm;
				if (ax_q == 2'd2) begin
					sqn_q <= 64'(sq_q + sqterm);
					root_q <= '0;
					bit_q <= 64'd1 << 62;
				end
			end
			ST_SQRT: begin
				// One digit pair of the integer square root per cycle.
				if (sqn_q >= root_q + bit_q) begin
					sqn_q <= sqn_q - (root_q + bit_q);
					root_q <= (root_q >> 1) + bit_q;
				end else root_q <= root_q >> 1;
				bit_q <= bit_q >> 2;
				if (cnt_q == 6'd31) len_q <= ((sqn_q >= root_q + bit_q) ?
				    32'((root_q >> 1) + bit_q) : 32'(root_q >> 1));
			end
			ST_DWAIT: begin
				if (drsp.done) begin
					case (dix_q)
						3'd0: uh_q[ax_q] <= hd_q[ax_q][31] ? 18'(-drsp.quo[17:0])
						    : drsp.quo[17:0];
						3'd1: ci_q[ax_q] <= qsat;
						default: nc_q[ax_q] <= qsat;
					endcase
				end
			end
			ST_STEP: begin
				vox_q[sax] <= vox_q[sax] + (uh_q[sax][17] ? 16'hFFFF
				    : ((uh_q[sax] != '0) ? 16'd1 : 16'd0));
				trav_q <= nc_q[sax];
				nc_q[sax] <= ncsum[TIME_W] ? TIME_MAX : ncsum[TIME_W-1:0];
				case (sax)
					2'd0: face_q <= (!uh_q[0][17] && uh_q[0] != '0) ? FACE_WEST : FACE_EAST;
					2'd1: face_q <= (!uh_q[1][17] && uh_q[1] != '0) ? FACE_BOT : FACE_TOP;
					default: face_q <= (!uh_q[2][17] && uh_q[2] != '0) ? FACE_SOUTH
					    : FACE_NORTH;
				endcase
			end
			ST_PMUL: prod_q <= 73'(uh_q[ax_q]) * $signed({1'b0, pt_t_q});
			ST_PADD: begin
				if (psum > 74'sd2147483647) r_pt_q[ax_q] <= 32'h7FFFFFFF;
				else if (psum < -74'sd2147483648) r_pt_q[ax_q] <= 32'h80000000;
				else r_pt_q[ax_q] <= psum[31:0];
			end
			ST_OUT: begin
				r_kind_q <= okind_q;
				for (int i = 0; i < 3; i++) r_vox_q[i] <= (okind_q == KIND_IDLE) ? '0 : vox_q[i];
				r_blk_q <= (okind_q == KIND_HIT) ? oblk_q : 8'd0;
				r_face_q <= (okind_q == KIND_HIT) ? face_q : FACE_TOP;
				r_dist_q <= (okind_q == KIND_HIT) ? trav_q[30:0]
				    : ((okind_q == KIND_MISS) ? lim_q : 31'd0);
				if (okind_q == KIND_QUERY || okind_q == KIND_IDLE)
					for (int i = 0; i < 3; i++) r_pt_q[i] <= '0;
			end
			default: ;
		endcase
	end

	assign out_valid = r_valid_q;
	assign kind = r_kind_q;
	assign voxel_x = r_vox_q[0];
	assign voxel_y = r_vox_q[1];
	assign voxel_z = r_vox_q[2];
	assign hit_block = r_blk_q;
	assign face = r_face_q;
	assign distance = r_dist_q;
	assign point_x = r_pt_q[0];
	assign point_y = r_pt_q[1];
	assign point_z = r_pt_q[2];
endmodule

/* dv/testbench.sv */
// Testbench for the voxel ray traversal block: directed and randomized rays checked against a built-in predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import vrt_pkg::*;

	localparam int FB = 16;
	localparam logic [63:0] TMAX = 64'hFF_FFFF_FFFF;
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_ANSWER = 1'b1;

	typedef struct packed {
		logic               action;
		logic signed [31:0] ox, oy, oz;
		logic signed [31:0] hx, hy, hz;
		logic [30:0]        limit;
		logic [7:0]         occ;
	} ray_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [15:0]        vx, vy, vz;
		logic [7:0]         blk;
		logic [2:0]         face;
		logic [30:0]        span;
		logic [31:0]        px, py, pz;
	} walk_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = 1'b0;
	logic signed [31:0] origin_x = '0, origin_y = '0, origin_z = '0;
	logic signed [31:0] heading_x = '0, heading_y = '0, heading_z = '0;
	logic [30:0] length_limit = '0;
	logic [7:0] occupancy = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] kind;
	logic signed [15:0] voxel_x, voxel_y, voxel_z;
	logic [7:0] hit_block;
	logic [2:0] face;
	logic [30:0] distance;
	logic signed [31:0] point_x, point_y, point_z;

	voxel_ray_traversal_top dut (.*);

	always #2 clk = ~clk;

	// Predictor state
	logic              active_q = 1'b0;
	logic signed [63:0] org_q[3];
	logic signed [63:0] unit_q[3];
	int                sgn_q[3];
	logic [15:0]       vox_q[3];
	logic [63:0]       cross_q[3];
	logic [63:0]       intv_q[3];
	logic [63:0]       trav_q;
	logic [2:0]        face_q;
	logic [63:0]       lim_q;

	ray_item_t    pending_items[$];
	walk_result_t expected_results[$];
	int errors = 0;
	bit hold_off = 0;
	bit drain_wait = 0;

	function automatic logic signed [63:0] floor_frac(logic signed [63:0] v);
		return v >>> FB;
	endfunction

	function automatic logic [63:0] sqrt64(logic [63:0] n);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] clamp_time(logic [63:0] t);
		return (t > TMAX) ? TMAX : t;
	endfunction

	function automatic logic [31:0] point_at(int ax, logic [63:0] t);
		logic signed [63:0] p;
		p = org_q[ax] + floor_frac(unit_q[ax] * $signed(t));
		if (p > 64'sd2147483647) p = 64'sd2147483647;
		if (p < -64'sd2147483648) p = -64'sd2147483648;
		return p[31:0];
	endfunction

	function automatic void step_axis(int ax);
		vox_q[ax] = vox_q[ax] + 16'(sgn_q[ax]);
		trav_q = cross_q[ax];
		cross_q[ax] = clamp_time(cross_q[ax] + intv_q[ax]);
		if (ax == 0) face_q = sgn_q[0] > 0 ? FACE_WEST : FACE_EAST;
		else if (ax == 1) face_q = sgn_q[1] > 0 ? FACE_BOT : FACE_TOP;
		else face_q = sgn_q[2] > 0 ? FACE_SOUTH : FACE_NORTH;
	endfunction

	// Compute the result one item causes and advance the predictor
	function automatic walk_result_t trace_step(ray_item_t it);
		walk_result_t r;
		logic signed [63:0] h[3];
		logic [63:0] sq, len, mag, frc, d;
		r = '0;
		if (it.action == ACT_START) begin
			org_q[0] = it.ox; org_q[1] = it.oy; org_q[2] = it.oz;
			h[0] = it.hx; h[1] = it.hy; h[2] = it.hz;
			sq = 0;
			for (int i = 0; i < 3; i++) begin
				mag = h[i] < 0 ? -h[i] : h[i];
				sq += mag * mag;
			end
			len = sqrt64(sq);
			for (int i = 0; i < 3; i++) begin
				if (len == 0) begin
					unit_q[i] = 0;
				end else begin
					mag = ((h[i] < 0 ? -h[i] : h[i]) << FB) / len;
					unit_q[i] = h[i] < 0 ? -$signed(mag) : $signed(mag);
				end
				sgn_q[i] = unit_q[i] > 0 ? 1 : (unit_q[i] < 0 ? -1 : 0);
				vox_q[i] = 16'(floor_frac(org_q[i]));
				if (sgn_q[i] == 0) begin
					cross_q[i] = TMAX;
					intv_q[i] = TMAX;
				end else begin
					mag = unit_q[i] < 0 ? -unit_q[i] : unit_q[i];
					frc = org_q[i] & 64'hFFFF;
					d = sgn_q[i] > 0 ? 64'h10000 - frc : frc;
					intv_q[i] = clamp_time((64'd1 << (2 * FB)) / mag);
					cross_q[i] = clamp_time((d << FB) / mag);
				end
			end
			trav_q = 0;
			face_q = FACE_TOP;
			lim_q = 64'(it.limit);
			active_q = 1'b1;
			r.kind = KIND_QUERY;
			{r.vx, r.vy, r.vz} = {vox_q[0], vox_q[1], vox_q[2]};
			return r;
		end
		if (!active_q) begin
			r.kind = KIND_IDLE;
			return r;
		end
		if (it.occ != 0) begin
			r.kind = KIND_HIT;
			{r.vx, r.vy, r.vz} = {vox_q[0], vox_q[1], vox_q[2]};
			r.blk = it.occ;
			r.face = face_q;
			r.span = trav_q[30:0];
			r.px = point_at(0, trav_q);
			r.py = point_at(1, trav_q);
			r.pz = point_at(2, trav_q);
			active_q = 1'b0;
			return r;
		end
		if (cross_q[0] < cross_q[1]) step_axis(cross_q[0] < cross_q[2] ? 0 : 2);
		else step_axis(cross_q[1] < cross_q[2] ? 1 : 2);
		{r.vx, r.vy, r.vz} = {vox_q[0], vox_q[1], vox_q[2]};
		if (trav_q <= lim_q) begin
			r.kind = KIND_QUERY;
			return r;
		end
		r.kind = KIND_MISS;
		r.face = FACE_TOP;
		r.span = lim_q[30:0];
		r.px = point_at(0, lim_q);
		r.py = point_at(1, lim_q);
		r.pz = point_at(2, lim_q);
		active_q = 1'b0;
		return r;
	endfunction

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return $urandom();
			default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
		endcase
	endfunction

	function automatic ray_item_t make_start(logic [31:0] ox, oy, oz, hx, hy, hz,
		logic [30:0] lim);
		ray_item_t it;
		it = '0;
		it.action = ACT_START;
		{it.ox, it.oy, it.oz} = {ox, oy, oz};
		{it.hx, it.hy, it.hz} = {hx, hy, hz};
		it.limit = lim;
		it.occ = 8'($urandom());
		return it;
	endfunction

	function automatic ray_item_t make_answer(logic [7:0] occ);
		ray_item_t it;
		it = '0;
		it.action = ACT_ANSWER;
		it.occ = occ;
		it.ox = $urandom();
		it.hz = $urandom();
		it.limit = 31'($urandom());
		return it;
	endfunction

	// Fill the item queue: directed rays first, then random walks
	initial begin
		logic [31:0] h3[3];
		logic [7:0] occv;
		int steps;
		// answer with no ray yet, then extremes
		pending_items.push_back(make_answer(8'hFF));
		pending_items.push_back(make_start(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0,
			31'h7FFF_FFFF));
		pending_items.push_back(make_answer(0));
		pending_items.push_back(make_answer(0));
		pending_items.push_back(make_start(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 31'h7FFF_FFFF));
		pending_items.push_back(make_answer(0));
		pending_items.push_back(make_answer(0));
		pending_items.push_back(make_answer(8'h01));
		// tie on all axes goes to z
		pending_items.push_back(make_start(32'h8000, 32'h8000, 32'h8000,
			32'h10000, 32'h10000, 32'h10000, 31'h40000));
		for (int i = 0; i < 4; i++) pending_items.push_back(make_answer(0));
		pending_items.push_back(make_answer(8'h80));
		// restart while active, then zero limit
		pending_items.push_back(make_start(0, 0, 0, 32'hFFFF_0000, 0, 0, 31'h7FFF_FFFF));
		pending_items.push_back(make_start(32'h12345, 32'hFFFE_8000, 0,
			32'h0, 32'hFFFF_FFFF, 32'h1, 31'd0));
		pending_items.push_back(make_answer(0));
		pending_items.push_back(make_answer(0));
		pending_items.push_back(make_start(0, 0, 0, 32'h1, 32'h1, 32'h1, 31'h10000));
		pending_items.push_back(make_answer(8'hFF));
		pending_items.push_back(make_answer(8'h55));
		// random rays with walks; mostly well-formed, some noise
		while (pending_items.size() < 1800) begin
			for (int i = 0; i < 3; i++) h3[i] = rand_word();
			if ($urandom_range(0, 9) == 0) h3[$urandom_range(0, 2)] = 0;
			pending_items.push_back(make_start(rand_word(), rand_word(), rand_word(),
				h3[0], h3[1], h3[2],
				$urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h80000))));
			steps = $urandom_range(0, 12);
			for (int s = 0; s < steps; s++) begin
				occv = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'h00;
				pending_items.push_back(make_answer(occv));
			end
			if ($urandom_range(0, 3) == 0) pending_items.push_back(make_answer(8'($urandom())));
		end
	end

	// Hold reset, then release it
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Driver: offer items from the queue with random gaps
	int send_gap = 0;
	int sent = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_results.push_back(trace_step(pending_items.pop_front()));
				sent++;
				if (sent == 600) drain_wait = 1;
				send_gap = gap_len();
			end
			if (drain_wait && expected_results.size() == 0 && !(in_valid && !in_stall))
				drain_wait = 0;
			if (in_valid && in_stall) begin
				// hold the payload
			end else if (send_gap > 0 || drain_wait || pending_items.size() == 0) begin
				if (send_gap > 0) send_gap--;
				in_valid <= 1'b0;
			end else begin
				in_valid <= 1'b1;
				action <= pending_items[0].action;
				origin_x <= pending_items[0].ox;
				origin_y <= pending_items[0].oy;
				origin_z <= pending_items[0].oz;
				heading_x <= pending_items[0].hx;
				heading_y <= pending_items[0].hy;
				heading_z <= pending_items[0].hz;
				length_limit <= pending_items[0].limit;
				occupancy <= pending_items[0].occ;
			end
		end
	end

	// Long receiver hold-off once, counted in cycles
	initial begin
		wait (sent == 300);
		hold_off = 1;
		repeat (2500) @(posedge clk);
		hold_off = 0;
	end

	// Monitor: random stall, compare each result with the oldest expectation
	int stall_gap = 0;
	walk_result_t want;
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					$error("result with no expectation, kind %0d", kind);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (kind !== want.kind) begin
						$error("kind exp %0d got %0d", want.kind, kind); errors++; end
					if (voxel_x !== want.vx) begin
						$error("voxel_x exp %0d got %0d", $signed(want.vx), voxel_x); errors++; end
					if (voxel_y !== want.vy) begin
						$error("voxel_y exp %0d got %0d", $signed(want.vy), voxel_y); errors++; end
					if (voxel_z !== want.vz) begin
						$error("voxel_z exp %0d got %0d", $signed(want.vz), voxel_z); errors++; end
					if (hit_block !== want.blk) begin
						$error("hit_block exp %0d got %0d", want.blk, hit_block); errors++; end
					if (face !== want.face) begin
						$error("face exp %0d got %0d", want.face, face); errors++; end
					if (distance !== want.span) begin
						$error("distance exp %h got %h", want.span, distance); errors++; end
					if (point_x !== want.px) begin
						$error("point_x exp %h got %h", want.px, point_x); errors++; end
					if (point_y !== want.py) begin
						$error("point_y exp %h got %h", want.py, point_y); errors++; end
					if (point_z !== want.pz) begin
						$error("point_z exp %h got %h", want.pz, point_z); errors++; end
				end
				stall_gap = gap_len();
			end
			if (hold_off) begin
				out_stall <= 1'b1;
			end else if (stall_gap > 0) begin
				stall_gap--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Finish once all items are in and all results are out
	initial begin
		wait (arst_n);
		wait (pending_items.size() == 0 && sent > 0 && !in_valid && expected_results.size() == 0);
		repeat (600) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// Timeout
	initial begin
		#8ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

/* filelist.f */
hdl/vrt_pkg.sv
hdl/vrt_divider.sv
hdl/voxel_ray_traversal_top.sv
dv/testbench.sv
